FILE: rtl/smts_pkg.sv
package smts_pkg;

  // Command codes carried in the low bit of the input tuser.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Stack selector for a pop: the low stack grows up, the high stack grows down.
  localparam logic SIDE_HIGH = 1'b0;
  localparam logic SIDE_LOW  = 1'b1;

  // Reset value of the pass threshold, in tenths.
  localparam logic [6:0] THRESH_RESET = 7'd60;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Control word handed from the front end to the store back end.
  typedef struct packed {
    logic    wr;
    logic    rd;
    status_t status;
    logic    went_low;
  } ctl_t;

endpackage

FILE: rtl/smts_front.sv
module smts_front
  import smts_pkg::*;
#(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [39:0]                  in_tdata,
  input  logic [1:0]                   in_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [6:0]                   cfg_data,
  output logic                         q_push,
  input  logic                         q_ready,
  output ctl_t                         q_ctl,
  output logic [$clog2(DEPTH)-1:0]     q_addr,
  output logic [DATA_WIDTH-1:0]        q_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] TOP_C   = CW'(DEPTH - 1);
  localparam logic [CW:0]   FULL_C  = (CW + 1)'(DEPTH);

  logic [6:0]    thresh_r;
  logic [CW-1:0] low_r, low_nxt;
  logic [CW-1:0] high_r, high_nxt;
  logic [CW:0]   sum;
  logic          full;
  logic          accept;
  logic          cmd;
  logic          side;
  logic [6:0]    grade;
  logic [CW-1:0] low_m1;
  logic [CW-1:0] hi_push_addr;
  logic [CW-1:0] hi_pop_addr;

  // Field extraction and fill level.
  assign cmd          = in_tuser[0];
  assign side         = in_tuser[1];
  assign grade        = in_tdata[38:32];
  assign accept       = in_tvalid && q_ready;
  assign in_tready    = q_ready;
  assign cfg_ready    = 1'b1;
  assign sum          = {1'b0, low_r} + {1'b0, high_r};
  assign full         = (sum >= FULL_C);
  assign low_m1       = low_r - 1'b1;
  assign hi_push_addr = TOP_C - high_r;
  assign hi_pop_addr  = DEPTH_C - high_r;
  assign q_push       = accept;
  assign q_data       = DATA_WIDTH'(in_tdata[31:0]);

  // Classify the item, pick the store address and the new stack counts.
  always_comb begin
    q_ctl.wr       = 1'b0;
    q_ctl.rd       = 1'b0;
    q_ctl.status   = ST_OK;
    q_ctl.went_low = 1'b0;
    q_addr         = low_r[AW-1:0];
    low_nxt        = low_r;
    high_nxt       = high_r;
    priority if (cmd == CMD_PUSH && full) begin
      q_ctl.status = ST_FULL;
    end else if (cmd == CMD_PUSH && grade >= thresh_r) begin
      q_ctl.wr       = 1'b1;
      q_ctl.went_low = 1'b1;
      low_nxt        = low_r + 1'b1;
    end else if (cmd == CMD_PUSH) begin
      q_ctl.wr = 1'b1;
      q_addr   = hi_push_addr[AW-1:0];
      high_nxt = high_r + 1'b1;
    end else if (side == SIDE_LOW) begin
      if (low_r == '0) begin
        q_ctl.status = ST_EMPTY;
      end else begin
        q_ctl.rd = 1'b1;
        q_addr   = low_m1[AW-1:0];
        low_nxt  = low_m1;
      end
    end else begin
      if (high_r == '0) begin
        q_ctl.status = ST_EMPTY;
      end else begin
        q_ctl.rd = 1'b1;
        q_addr   = hi_pop_addr[AW-1:0];
        high_nxt = high_r - 1'b1;
      end
    end
  end

  // Stack counts move as soon as an item is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '0;
    end else if (accept) begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_valid) begin
      thresh_r <= cfg_data;
    end
  end

`ifndef SYNTH
  // The two stacks together never hold more than the store.
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    sum <= FULL_C)
    else $error("stack counts exceed the store depth");

  // A successful push grows the total by exactly one.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && q_ctl.wr |=> sum == $past(sum) + 1'b1)
    else $error("push did not grow the fill level by one");

  // A successful pop shrinks the total by exactly one.
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && q_ctl.rd |=> sum + 1'b1 == $past(sum))
    else $error("pop did not shrink the fill level by one");

  // Store accesses only ever go with an ok status, and never both at once.
  a_access_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (q_ctl.wr || q_ctl.rd) |-> q_ctl.status == ST_OK && !(q_ctl.wr && q_ctl.rd))
    else $error("store access issued with an error status");
`endif

endmodule

FILE: rtl/smts_queue.sv
module smts_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  // Two-entry queue between the front end and the store.
  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Payload slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

FILE: rtl/smts_back.sv
module smts_back
  import smts_pkg::*;
#(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  ctl_t                     q_ctl,
  input  logic [$clog2(DEPTH)-1:0] q_addr,
  input  logic [DATA_WIDTH-1:0]    q_data,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [31:0]              out_tdata,
  output logic [2:0]               out_tuser
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_r;
  logic                  out_valid_r;
  ctl_t                  ctl_r;
  logic                  adv;
  logic [DATA_WIDTH-1:0] word;

  // Take the next queued item when the output register is free or draining.
  assign adv        = q_valid && (!out_valid_r || out_tready);
  assign q_pop      = adv;
  assign out_tvalid = out_valid_r;
  assign word       = ctl_r.rd ? rd_r : '0;
  assign out_tdata  = 32'(word);
  assign out_tuser  = {ctl_r.went_low, ctl_r.status};

  // Store: at most one write or one registered read for each item.
  always_ff @(posedge clk) begin
    if (adv && q_ctl.wr) begin
      mem[q_addr] <= q_data;
    end
    if (adv && q_ctl.rd) begin
      rd_r <= mem[q_addr];
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r <= q_ctl;
    end
  end

endmodule

FILE: rtl/shared_memory_twin_stack_unit.sv
// Two LIFO stacks sharing one store of DEPTH words: the low stack fills from
// entry 0 upward, the high stack from entry DEPTH-1 downward.
// Input channel (in_*): one item is a push (tuser bit 0 low) or a pop. A push
// goes to the low stack when its grade is at or above the pass threshold.
// A pop names its stack in tuser bit 1 (1 low stack, 0 high stack).
// Result channel (out_*): exactly one item for each input item, in order,
// carrying the popped word, a status (ok, full, empty) and the went-low flag.
// Configuration channel (cfg_*): writes the 7-bit pass threshold; always ready.
// The user writes it only while the block is idle; the block does not enforce it.
// A result passes through the queue slot and then the output register once its
// input item is accepted. Throughput is one item per cycle while the receiver
// does not stall, set by the single store port used once per item.
// The front end updates the stack counts on acceptance and a two-entry queue
// feeds the store back end, so pushes and pops reach the store in order.
// When the receiver stalls, the result holds in the output register, the
// queue fills and then in_tready falls. Reset clears both counts, the queue
// and the output valid flag and sets the threshold to 60; the store itself is
// not cleared and needs no clearing pass.
module shared_memory_twin_stack_unit
  import smts_pkg::*;
#(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] entry_data, [38:32] grade, [39] zero
  input  logic [1:0]  in_tuser,   // [0] cmd, [1] pop_side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] popped_data
  output logic [2:0]  out_tuser,  // [1:0] status, [2] went_low
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // [6:0] pass_threshold
);

  localparam int AW = $clog2(DEPTH);
  localparam int QW = DATA_WIDTH + AW + $bits(ctl_t);

  logic                  f_push;
  logic                  f_ready;
  ctl_t                  f_ctl;
  logic [AW-1:0]         f_addr;
  logic [DATA_WIDTH-1:0] f_data;
  logic                  b_valid;
  logic                  b_pop;
  logic [QW-1:0]         b_word;
  ctl_t                  b_ctl;
  logic [AW-1:0]         b_addr;
  logic [DATA_WIDTH-1:0] b_data;

  // Front end: classification, threshold and stack counts.
  smts_front #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_push    (f_push),
    .q_ready   (f_ready),
    .q_ctl     (f_ctl),
    .q_addr    (f_addr),
    .q_data    (f_data)
  );

  // Queue between the two halves.
  smts_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_ready (f_ready),
    .push_data  ({f_data, f_addr, f_ctl}),
    .pop_valid  (b_valid),
    .pop        (b_pop),
    .pop_data   (b_word)
  );

  assign {b_data, b_addr, b_ctl} = b_word;

  // Back end: store access and result register.
  smts_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_pop      (b_pop),
    .q_ctl      (b_ctl),
    .q_addr     (b_addr),
    .q_data     (b_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
